@@ sv/bfa_pkg.sv @@
// bfa_pkg: shared types and constants of the bitmap frame allocator
// holds the command format passed from the front end to the back end through the queue
// no dependencies

package bfa_pkg;

	localparam int FRAME_SHIFT = 12;
	localparam int WORD_BITS   = 32;
	localparam int FRAME_W     = 21;
	localparam int FIRST_W     = 20;
	localparam int WIDX_W      = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [WORD_BITS-1:0] FULL_WORD = 32'hFFFF_FFFF;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_OOM   = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef enum logic [1:0] {
		FUNC_ALLOC   = 2'd0,
		FUNC_FREE    = 2'd1,
		FUNC_RELEASE = 2'd2,
		FUNC_RESERVE = 2'd3
	} func_t;

	typedef struct packed {
		logic               alloc;
		logic               used;
		logic [FRAME_W-1:0] first;
		logic [FRAME_W-1:0] stop;
		logic [1:0]         status;
	} cmd_t;

endpackage

@@ sv/bitmap_frame_allocator_core.sv @@
// operations pass through the front pipeline and the command queue to the back end:
// allocation scans the whole words below frame_limit for the first clear bit,
// free and regions read-modify-write each touched word
// one operation executes at a time; the front end accepts up to four more meanwhile
// after reset the bitmap is set to all used in a pass over every word, no transfer
// is accepted until that pass ends; frame_limit resets to 0

module bitmap_frame_allocator_core #(
	parameter int FRAME_CAPACITY = 32768
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [31:0] target_addr,
	input  logic [31:0] length,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] alloc_addr,
	output logic [1:0]  status
);

	logic [15:0]   frame_limit_q;
	logic          hold;
	logic          fq_valid;
	logic          fq_ready;
	bfa_pkg::cmd_t fq_data;
	logic          qb_valid;
	logic          qb_ready;
	bfa_pkg::cmd_t qb_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_limit_q <= '0;
		end else if (cfg_we) begin
			frame_limit_q <= cfg_wdata;
		end
	end

	bfa_front #(
		.FRAME_CAPACITY(FRAME_CAPACITY)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.target_addr  (target_addr),
		.length       (length),
		.hold         (hold),
		.q_valid      (fq_valid),
		.q_ready      (fq_ready),
		.q_data       (fq_data)
	);

	bfa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_data  (fq_data),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_data   (qb_data)
	);

	bfa_back #(
		.FRAME_CAPACITY(FRAME_CAPACITY)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.frame_limit   (frame_limit_q),
		.cmd_valid     (qb_valid),
		.cmd_ready     (qb_ready),
		.cmd           (qb_data),
		.clearing      (hold),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.alloc_addr    (alloc_addr),
		.status        (status)
	);

endmodule

@@ sv/bfa_front.sv @@
// bfa_front: accepts operations and turns them into frame ranges
// two-stage pipeline producing bfa_pkg::cmd_t entries for the command queue
// depends on bfa_pkg

module bfa_front #(
	parameter int FRAME_CAPACITY = 32768
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           func,
	input  logic [31:0]          target_addr,
	input  logic [31:0]          length,
	input  logic                 hold,
	output logic                 q_valid,
	input  logic                 q_ready,
	output bfa_pkg::cmd_t        q_data
);

	localparam int FW = bfa_pkg::FRAME_W;
	localparam logic [FW-1:0] CAP_FR = FW'(FRAME_CAPACITY);

	logic                 adv;
	logic                 v_s1;
	logic                 v_s2;
	bfa_pkg::func_t       func_s1;
	bfa_pkg::func_t       func_s2;
	logic [31:0]          base_s1;
	logic [31:0]          len_s1;
	logic [32:0]          sum_s1;
	logic [bfa_pkg::FIRST_W-1:0] first_s2;
	logic [FW-1:0]        count_s2;
	logic [32:0]          eff_len;
	logic [FW-1:0]        count_d;
	logic [FW-1:0]        stop_raw;

	assign adv      = !v_s2 || q_ready;
	assign in_ready = adv && !hold;

	// effective length with the region end clipped at the top of the address space, and its frame count (one for a free)
	always_comb begin
		if (sum_s1[32]) begin
			eff_len = {1'b1, 32'd0} - {1'b0, base_s1};
		end else begin
			eff_len = {1'b0, len_s1};
		end
		if (func_s1 == bfa_pkg::FUNC_FREE) begin
			count_d = FW'(1);
		end else begin
			count_d = eff_len[32:12] + FW'(|eff_len[11:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid && !hold;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			func_s1  <= bfa_pkg::func_t'(func);
			base_s1  <= target_addr;
			len_s1   <= length;
			sum_s1   <= {1'b0, target_addr} + {1'b0, length};
			func_s2  <= func_s1;
			first_s2 <= base_s1[31:bfa_pkg::FRAME_SHIFT];
			count_s2 <= count_d;
		end
	end

	assign stop_raw = {1'b0, first_s2} + count_s2;
	assign q_valid  = v_s2;

	always_comb begin
		q_data.alloc  = (func_s2 == bfa_pkg::FUNC_ALLOC);
		q_data.used   = (func_s2 == bfa_pkg::FUNC_RESERVE);
		q_data.first  = {1'b0, first_s2};
		q_data.stop   = stop_raw;
		q_data.status = bfa_pkg::ST_OK;
		if (count_s2 == '0) begin
			q_data.stop = {1'b0, first_s2};
		end else if (stop_raw > CAP_FR) begin
			q_data.stop   = CAP_FR;
			q_data.status = bfa_pkg::ST_RANGE;
		end
	end

endmodule

@@ sv/bfa_queue.sv @@
// bfa_queue: short command queue between front end and back end
// holds bfa_pkg::cmd_t entries, depth bfa_pkg::QUEUE_DEPTH
// depends on bfa_pkg

module bfa_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  bfa_pkg::cmd_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output bfa_pkg::cmd_t pop_data
);

	localparam int DEPTH = bfa_pkg::QUEUE_DEPTH;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	bfa_pkg::cmd_t slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (count_q != FULL_CNT);
	assign pop_valid  = (count_q != '0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ sv/bfa_back.sv @@
// bfa_back: occupancy bitmap memory and the sequencer that executes commands
// first-fit scan for allocation, word-wise read-modify-write for regions, result register
// depends on bfa_pkg

module bfa_back #(
	parameter int FRAME_CAPACITY = 32768
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [15:0]   frame_limit,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  bfa_pkg::cmd_t cmd,
	output logic          clearing,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [31:0]   alloc_addr,
	output logic [1:0]    status
);

	localparam int WORD_COUNT = (FRAME_CAPACITY + 31) / 32;
	localparam int AW = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int XW = bfa_pkg::WIDX_W;
	localparam logic [XW-1:0] WC_LAST = XW'(WORD_COUNT - 1);
	localparam logic [XW-1:0] WC_NUM  = XW'(WORD_COUNT);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_RRD,
		S_RMW,
		S_DONE
	} state_t;

	state_t        state_q;
	logic [31:0]   occ_q [WORD_COUNT];
	logic [31:0]   rdata_q;
	bfa_pkg::cmd_t cmd_q;
	logic [XW-1:0] wi_q;
	logic [XW-1:0] last_w_q;
	logic [XW-1:0] chk_idx_q;
	logic          chk_v_q;
	logic [31:0]   res_addr_q;
	logic [1:0]    res_st_q;
	logic          out_valid_q;
	logic [31:0]   out_addr_q;
	logic [1:0]    out_st_q;

	logic          mem_we;
	logic [AW-1:0] wr_addr;
	logic [31:0]   wr_data;
	logic [XW-1:0] lim_raw;
	logic [XW-1:0] lim;
	logic [bfa_pkg::FRAME_W-1:0] q_stop_m1;
	logic [bfa_pkg::FRAME_W-1:0] stop_m1;
	logic          zero_found;
	logic [4:0]    zero_bit;
	logic [4:0]    lo;
	logic [4:0]    hi;
	logic [31:0]   mask;
	logic [31:0]   mod_word;
	logic          issue;

	assign cmd_ready  = (state_q == S_IDLE);
	assign clearing   = (state_q == S_CLEAR);
	assign out_valid  = out_valid_q;
	assign alloc_addr = out_addr_q;
	assign status     = out_st_q;

	assign lim_raw   = {5'd0, frame_limit[15:5]};
	assign lim       = (lim_raw > WC_NUM) ? WC_NUM : lim_raw;
	assign q_stop_m1 = cmd.stop - bfa_pkg::FRAME_W'(1);
	assign stop_m1   = cmd_q.stop - bfa_pkg::FRAME_W'(1);
	assign issue     = (wi_q <= last_w_q);

	// lowest clear bit of the word just read
	always_comb begin
		zero_found = (rdata_q != bfa_pkg::FULL_WORD);
		zero_bit   = 5'd0;
		for (int b = 31; b >= 0; b--) begin
			if (!rdata_q[b]) begin
				zero_bit = 5'(b);
			end
		end
	end

	always_comb begin
		lo = (wi_q == cmd_q.first[20:5]) ? cmd_q.first[4:0] : 5'd0;
		hi = (wi_q == last_w_q) ? stop_m1[4:0] : 5'd31;
		mask = (bfa_pkg::FULL_WORD << lo) & (bfa_pkg::FULL_WORD >> (5'd31 - hi));
		mod_word = cmd_q.used ? (rdata_q | mask) : (rdata_q & ~mask);
	end

	always_comb begin
		mem_we  = 1'b0;
		wr_addr = wi_q[AW-1:0];
		wr_data = bfa_pkg::FULL_WORD;
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
			end
			S_SCAN: begin
				mem_we  = chk_v_q && zero_found;
				wr_addr = chk_idx_q[AW-1:0];
				wr_data = rdata_q | (32'd1 << zero_bit);
			end
			S_RMW: begin
				mem_we  = 1'b1;
				wr_data = mod_word;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			occ_q[wr_addr] <= wr_data;
		end
		rdata_q <= occ_q[wi_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			wi_q        <= '0;
			last_w_q    <= '0;
			chk_idx_q   <= '0;
			chk_v_q     <= 1'b0;
			cmd_q       <= '0;
			res_addr_q  <= '0;
			res_st_q    <= bfa_pkg::ST_OK;
			out_valid_q <= 1'b0;
			out_addr_q  <= '0;
			out_st_q    <= bfa_pkg::ST_OK;
		end else begin
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					if (wi_q == WC_LAST) begin
						wi_q    <= '0;
						state_q <= S_IDLE;
					end else begin
						wi_q <= wi_q + XW'(1);
					end
				end
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q      <= cmd;
						res_addr_q <= '0;
						res_st_q   <= (cmd.alloc && lim == '0) ? bfa_pkg::ST_OOM : cmd.status;
						if (cmd.alloc) begin
							if (lim == '0) begin
								state_q  <= S_DONE;
							end else begin
								wi_q     <= '0;
								last_w_q <= lim - XW'(1);
								chk_v_q  <= 1'b0;
								state_q  <= S_SCAN;
							end
						end else if (cmd.first < cmd.stop) begin
							wi_q     <= cmd.first[20:5];
							last_w_q <= q_stop_m1[20:5];
							state_q  <= S_RRD;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_SCAN: begin
					if (issue) begin
						wi_q <= wi_q + XW'(1);
					end
					chk_v_q   <= issue;
					chk_idx_q <= wi_q;
					if (chk_v_q && zero_found) begin
						res_addr_q <= {chk_idx_q[14:0], zero_bit, 12'd0};
						res_st_q   <= bfa_pkg::ST_OK;
						state_q    <= S_DONE;
					end else if (chk_v_q && chk_idx_q == last_w_q) begin
						res_st_q <= bfa_pkg::ST_OOM;
						state_q  <= S_DONE;
					end
				end
				S_RRD: begin
					state_q <= S_RMW;
				end
				S_RMW: begin
					if (wi_q == last_w_q) begin
						state_q <= S_DONE;
					end else begin
						wi_q    <= wi_q + XW'(1);
						state_q <= S_RRD;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_addr_q  <= res_addr_q;
						out_st_q    <= res_st_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
